### rtl/swba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swba_pkg
// Shared constants, types and helpers of the stereo waveform bin averager.
// ---------------------------------------------------------------------------
package swba_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int LEVEL_BITS  = 16;
	localparam int COUNT_BITS  = 16;
	localparam int POS_BITS    = 16;
	localparam int SPB_BITS    = 16;
	localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
	localparam int ITER_BITS   = $clog2(SAMPLE_BITS + 1);

	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// Register word index, taken from paddr[2]
	localparam logic REG_SAMPLES_PER_BIN = 1'b0;

	localparam logic [SPB_BITS-1:0] SPB_RESET = SPB_BITS'(1);

	// Largest level seen on the output port
	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX =
		(SAMPLE_BITS > LEVEL_BITS) ? {LEVEL_BITS{1'b1}} : LEVEL_BITS'(1 << (SAMPLE_BITS - 1));

	// One closed bin on its way to the divider
	typedef struct packed {
		logic [SUM_BITS-1:0]   left_sum;
		logic [SUM_BITS-1:0]   right_sum;
		logic [COUNT_BITS-1:0] left_count;
		logic [COUNT_BITS-1:0] right_count;
		logic                  last;
	} bin_rec_t;

	// Absolute value; the most negative code maps to 2^(SAMPLE_BITS-1)
	function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic signed [SAMPLE_BITS-1:0] s);
		logic [SAMPLE_BITS-1:0] v;
		begin
			v = s;
			magnitude = v[SAMPLE_BITS-1] ? (~v + SAMPLE_BITS'(1)) : v;
		end
	endfunction

endpackage
`default_nettype wire

### rtl/swba_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swba_front
// Accepts sample pairs, accumulates magnitudes and nonzero counts of the
// open bin, and hands each closed bin to the queue.
// ---------------------------------------------------------------------------
module swba_front
	import swba_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] left_sample,
	input  wire logic signed [SAMPLE_BITS-1:0] right_sample,
	input  wire logic                          frame_end,
	input  wire logic [SPB_BITS-1:0]           samples_per_bin,
	input  wire logic                          q_full,
	output logic                               q_push,
	output bin_rec_t                           q_wdata
);

	logic [SUM_BITS-1:0]    lsum_q, rsum_q, lsum_nxt, rsum_nxt;
	logic [COUNT_BITS-1:0]  lcnt_q, rcnt_q, lcnt_nxt, rcnt_nxt;
	logic [POS_BITS-1:0]    pos_q, pos_inc;
	logic [SAMPLE_BITS-1:0] mag_l, mag_r;
	logic [SPB_BITS-1:0]    bin_size;
	logic                   closes, accept;

	always_comb begin
		mag_l    = magnitude(left_sample);
		mag_r    = magnitude(right_sample);
		bin_size = (samples_per_bin == '0) ? SPB_BITS'(1) : samples_per_bin;
		pos_inc  = pos_q + POS_BITS'(1);
		// close on frame end, on a full bin, or when the position wraps
		closes   = frame_end || (pos_inc >= bin_size) || (pos_inc == '0);
		lsum_nxt = lsum_q + SUM_BITS'(mag_l);
		rsum_nxt = rsum_q + SUM_BITS'(mag_r);
		lcnt_nxt = lcnt_q + COUNT_BITS'(mag_l != '0);
		rcnt_nxt = rcnt_q + COUNT_BITS'(mag_r != '0);
	end

	// only a closing pair needs room in the queue
	assign in_ready = !q_full || !closes;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && closes;

	always_comb begin
		q_wdata.left_sum    = lsum_nxt;
		q_wdata.right_sum   = rsum_nxt;
		q_wdata.left_count  = lcnt_nxt;
		q_wdata.right_count = rcnt_nxt;
		q_wdata.last        = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsum_q <= '0;
			rsum_q <= '0;
			lcnt_q <= '0;
			rcnt_q <= '0;
			pos_q  <= '0;
		end else if (accept) begin
			if (closes) begin
				lsum_q <= '0;
				rsum_q <= '0;
				lcnt_q <= '0;
				rcnt_q <= '0;
				pos_q  <= '0;
			end else begin
				lsum_q <= lsum_nxt;
				rsum_q <= rsum_nxt;
				lcnt_q <= lcnt_nxt;
				rcnt_q <= rcnt_nxt;
				pos_q  <= pos_inc;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/swba_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swba_queue
// Short queue of closed bins between the accumulator and the divider.
// ---------------------------------------------------------------------------
module swba_queue
	import swba_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire bin_rec_t wdata,
	input  wire logic     pop,
	output bin_rec_t      rdata,
	output logic          full,
	output logic          empty
);

	bin_rec_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0]  count_q;
	logic                  do_push, do_pop;

	assign full    = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entry_q[rd_ptr_q];

	function automatic logic [QPTR_BITS-1:0] next_ptr(input logic [QPTR_BITS-1:0] p);
		next_ptr = (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_BITS'(1);
			end
		end
	end

endmodule
`default_nettype wire

### rtl/swba_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swba_div
// Takes a closed bin from the queue, divides both channel sums by their
// nonzero counts one quotient bit per cycle, and holds the result in the
// output register.
// ---------------------------------------------------------------------------
module swba_div
	import swba_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     q_empty,
	input  wire bin_rec_t q_rdata,
	output logic          q_pop,
	output logic          out_valid,
	input  wire logic     out_ready,
	output logic [LEVEL_BITS-1:0] left_level,
	output logic [LEVEL_BITS-1:0] right_level,
	output logic          last_of_frame
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]             state_q;
	logic [ITER_BITS-1:0]   iter_q;
	logic [COUNT_BITS-1:0]  l_rem_q, r_rem_q, l_div_q, r_div_q;
	logic [SAMPLE_BITS-1:0] l_dvd_q, r_dvd_q;
	logic                   l_zero_q, r_zero_q, last_q;
	logic                   out_valid_q, out_free;

	logic [COUNT_BITS:0]    l_trial, r_trial, l_diff, r_diff;
	logic                   l_ge, r_ge;
	logic [COUNT_BITS-1:0]  l_rem_nxt, r_rem_nxt;

	// Restoring step: the upper dividend bits are already below the divisor,
	// so SAMPLE_BITS steps give the whole quotient.
	always_comb begin
		l_trial   = {l_rem_q, l_dvd_q[SAMPLE_BITS-1]};
		r_trial   = {r_rem_q, r_dvd_q[SAMPLE_BITS-1]};
		l_diff    = l_trial - {1'b0, l_div_q};
		r_diff    = r_trial - {1'b0, r_div_q};
		l_ge      = (l_trial >= {1'b0, l_div_q});
		r_ge      = (r_trial >= {1'b0, r_div_q});
		l_rem_nxt = l_ge ? l_diff[COUNT_BITS-1:0] : l_trial[COUNT_BITS-1:0];
		r_rem_nxt = r_ge ? r_diff[COUNT_BITS-1:0] : r_trial[COUNT_BITS-1:0];
	end

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						iter_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					iter_q <= iter_q + ITER_BITS'(1);
					if (iter_q == ITER_BITS'(SAMPLE_BITS - 1)) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			l_rem_q  <= q_rdata.left_sum[SUM_BITS-1:SAMPLE_BITS];
			r_rem_q  <= q_rdata.right_sum[SUM_BITS-1:SAMPLE_BITS];
			l_dvd_q  <= q_rdata.left_sum[SAMPLE_BITS-1:0];
			r_dvd_q  <= q_rdata.right_sum[SAMPLE_BITS-1:0];
			l_div_q  <= q_rdata.left_count;
			r_div_q  <= q_rdata.right_count;
			l_zero_q <= (q_rdata.left_count == '0);
			r_zero_q <= (q_rdata.right_count == '0);
			last_q   <= q_rdata.last;
		end else if (state_q == ST_DIV) begin
			l_rem_q <= l_rem_nxt;
			r_rem_q <= r_rem_nxt;
			l_dvd_q <= {l_dvd_q[SAMPLE_BITS-2:0], l_ge};
			r_dvd_q <= {r_dvd_q[SAMPLE_BITS-2:0], r_ge};
		end
		if (state_q == ST_HOLD && out_free) begin
			left_level    <= l_zero_q ? '0 : LEVEL_BITS'(l_dvd_q);
			right_level   <= r_zero_q ? '0 : LEVEL_BITS'(r_dvd_q);
			last_of_frame <= last_q;
		end
	end

endmodule
`default_nettype wire

### rtl/stereo_waveform_bin_averager_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stereo_waveform_bin_averager_top
// Top level: register port, accumulator front, bin queue and divider back.
// ---------------------------------------------------------------------------
// Sample pairs that do not close a bin are taken one per cycle. A closing
// pair (full bin or frame_end) goes into a two-entry queue; the divider
// takes one bin from it at a time: it loads the bin, works out one quotient
// bit per cycle for both channels at once, then loads the output register
// once the output is free, and only then takes the next bin. Input stalls
// only when a closing pair finds the queue full. samples_per_bin sits at
// word 0; a value of 0 acts as 1.
module stereo_waveform_bin_averager_top
	import swba_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [PADDR_BITS-1:0]         paddr,
	input  wire logic [PDATA_BITS-1:0]         pwdata,
	output logic [PDATA_BITS-1:0]              prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] left_sample,
	input  wire logic signed [SAMPLE_BITS-1:0] right_sample,
	input  wire logic                          frame_end,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [LEVEL_BITS-1:0]              left_level,
	output logic [LEVEL_BITS-1:0]              right_level,
	output logic                               last_of_frame
);

	logic [SPB_BITS-1:0] spb_q;
	logic                cfg_wr;
	logic                q_push, q_pop, q_full, q_empty;
	bin_rec_t            q_wdata, q_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SAMPLES_PER_BIN);
	assign prdata = (paddr[2] == REG_SAMPLES_PER_BIN) ? PDATA_BITS'(spb_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spb_q <= SPB_RESET;
		end else if (cfg_wr) begin
			spb_q <= pwdata[SPB_BITS-1:0];
		end
	end

	swba_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.left_sample     (left_sample),
		.right_sample    (right_sample),
		.frame_end       (frame_end),
		.samples_per_bin (spb_q),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_wdata         (q_wdata)
	);

	swba_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	swba_div u_div (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_rdata       (q_rdata),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.left_level    (left_level),
		.right_level   (right_level),
		.last_of_frame (last_of_frame)
	);

endmodule
`default_nettype wire

### rtl/swba_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swba_checker
// Port-level checks of the bin averager, bound to the top level.
// ---------------------------------------------------------------------------
module swba_checker
	import swba_pkg::*;
(
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          psel,
	input wire logic                          penable,
	input wire logic                          pwrite,
	input wire logic [PADDR_BITS-1:0]         paddr,
	input wire logic [PDATA_BITS-1:0]         pwdata,
	input wire logic [PDATA_BITS-1:0]         prdata,
	input wire logic                          pready,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic signed [SAMPLE_BITS-1:0] left_sample,
	input wire logic signed [SAMPLE_BITS-1:0] right_sample,
	input wire logic                          frame_end,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [LEVEL_BITS-1:0]         left_level,
	input wire logic [LEVEL_BITS-1:0]         right_level,
	input wire logic                          last_of_frame
);

	// a stalled result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(left_level) && $stable(right_level)
			&& $stable(last_of_frame))
		else $error("result changed while stalled");

	// levels never exceed full scale
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_level <= LEVEL_MAX) && (right_level <= LEVEL_MAX))
		else $error("level above full scale");

	// a register write reads back on the next cycle
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr[2] == REG_SAMPLES_PER_BIN)
		##1 (paddr[2] == REG_SAMPLES_PER_BIN)
		|-> prdata == PDATA_BITS'($past(pwdata[SPB_BITS-1:0])))
		else $error("register readback mismatch");

	// a waiting sample pair holds until its transfer
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(left_sample)
			&& $stable(right_sample) && $stable(frame_end))
		else $error("input pair changed while stalled");

endmodule

bind stereo_waveform_bin_averager_top swba_checker u_swba_checker (.*);
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Checks the stereo waveform bin averager against a cycle-free model of the
// bin sums, the nonzero counts and the floored column levels. Directed cases
// cover sample extremes, frame closing and bin size corner cases. Random
// streams then run under three idling patterns, with the bin size rewritten
// between blocks.
// ---------------------------------------------------------------------------
module tb;
	import swba_pkg::*;

	localparam logic [PADDR_BITS-1:0] BIN_SIZE_ADDR = PADDR_BITS'(4 * REG_SAMPLES_PER_BIN);
	localparam int SETTLE_CYCLES = 40;
	localparam int BLOCK_ITEMS   = 40;
	localparam int REPORT_LIMIT  = 100;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] left_level;
		logic [LEVEL_BITS-1:0] right_level;
		logic                  last_of_frame;
	} column_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [PADDR_BITS-1:0]         paddr = '0;
	logic [PDATA_BITS-1:0]         pwdata = '0;
	logic [PDATA_BITS-1:0]         prdata;
	logic                          pready;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic signed [SAMPLE_BITS-1:0] left_sample = '0;
	logic signed [SAMPLE_BITS-1:0] right_sample = '0;
	logic                          frame_end = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [LEVEL_BITS-1:0]         left_level;
	logic [LEVEL_BITS-1:0]         right_level;
	logic                          last_of_frame;

	column_t pending_columns[$];
	int      errors = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;

	// Model copy of the register and of the open bin
	logic [SPB_BITS-1:0]   bin_size_reg = SPB_RESET;
	logic [SUM_BITS-1:0]   left_acc = '0;
	logic [SUM_BITS-1:0]   right_acc = '0;
	logic [COUNT_BITS-1:0] left_hits = '0;
	logic [COUNT_BITS-1:0] right_hits = '0;
	logic [POS_BITS-1:0]   pairs_in_bin = '0;

	stereo_waveform_bin_averager_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.frame_end    (frame_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_level   (left_level),
		.right_level  (right_level),
		.last_of_frame(last_of_frame)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [SAMPLE_BITS-1:0] abs_sample(input logic [SAMPLE_BITS-1:0] raw);
		return raw[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - raw) : raw;
	endfunction

	function automatic logic [LEVEL_BITS-1:0] mean_level(input logic [SUM_BITS-1:0] sum,
		input logic [COUNT_BITS-1:0] hits);
		logic [SUM_BITS-1:0] quotient;
		if (hits == '0)
			return '0;
		quotient = sum / SUM_BITS'(hits);
		return quotient[LEVEL_BITS-1:0];
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] rand_sample();
		logic [2:0] pick;
		pick = 3'($urandom_range(7));
		case ($urandom_range(9))
			0, 1: return '0;
			2: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			3: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			4: return pick[2] ? ~SAMPLE_BITS'(pick[1:0]) : SAMPLE_BITS'(pick[1:0]);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [SPB_BITS-1:0] rand_bin_size();
		case ($urandom_range(19))
			0: return '0;
			1: return '1;
			2: return SPB_BITS'(1);
			3: return SPB_BITS'($urandom_range(41, 300));
			4, 5, 6, 7, 8: return SPB_BITS'($urandom_range(9, 40));
			default: return SPB_BITS'($urandom_range(2, 8));
		endcase
	endfunction

	// Fold one accepted pair into the open bin; close it on a full bin, a frame end or a position wrap
	task automatic accumulate_pair(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r,
		input logic fe);
		logic [SAMPLE_BITS-1:0] ml;
		logic [SAMPLE_BITS-1:0] mr;
		logic [SPB_BITS-1:0]    size;
		column_t                col;
		ml = abs_sample(l);
		mr = abs_sample(r);
		size = (bin_size_reg == '0) ? SPB_BITS'(1) : bin_size_reg;
		if (ml != '0) begin
			left_acc += SUM_BITS'(ml);
			left_hits += 1'b1;
		end
		if (mr != '0) begin
			right_acc += SUM_BITS'(mr);
			right_hits += 1'b1;
		end
		pairs_in_bin += 1'b1;
		if (fe || pairs_in_bin >= POS_BITS'(size) || pairs_in_bin == '0) begin
			col.left_level = mean_level(left_acc, left_hits);
			col.right_level = mean_level(right_acc, right_hits);
			col.last_of_frame = fe;
			pending_columns = {pending_columns, col};
			left_acc = '0;
			right_acc = '0;
			left_hits = '0;
			right_hits = '0;
			pairs_in_bin = '0;
		end
	endtask

	task automatic send_pair(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r,
		input logic fe);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		left_sample <= l;
		right_sample <= r;
		frame_end <= fe;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		accumulate_pair(l, r, fe);
	endtask

	// Read the bin size register and compare with the model copy
	task automatic check_bin_size();
		logic [PDATA_BITS-1:0] data;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= BIN_SIZE_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (data[SPB_BITS-1:0] !== bin_size_reg) begin
			$display("%0t: bin size readback mismatch: expected %0d, got %0d", $time,
				bin_size_reg, data[SPB_BITS-1:0]);
			errors++;
		end
	endtask

	// Hold psel high: the readback follows as the next transfer
	task automatic write_bin_size(input logic [PDATA_BITS-1:0] word);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= BIN_SIZE_ADDR;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		bin_size_reg = word[SPB_BITS-1:0];
		check_bin_size();
	endtask

	// Drop valid, drain every pending column, then let the divider go quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_columns.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_bin_size();
		check_bin_size();
		send_pair(16'h8000, 16'h7FFF, 1'b0);
		send_pair(16'h0000, 16'h0000, 1'b0);
		settle();
	endtask

	task automatic test_level_extremes();
		write_bin_size(32'd4);
		send_pair(16'h8000, 16'h0000, 1'b0);
		send_pair(16'h7FFF, 16'h0000, 1'b0);
		send_pair(16'hFFFF, 16'h0000, 1'b0);
		send_pair(16'h0001, 16'h0000, 1'b0);
		settle();
	endtask

	task automatic test_frame_close();
		// full bin on the last pair of the frame
		write_bin_size(32'd2);
		send_pair(16'h0064, 16'hFFFB, 1'b0);
		send_pair(16'h0000, 16'hFFF9, 1'b1);
		settle();
		// partial bin closed by frame end
		write_bin_size(32'd5);
		send_pair(16'h1234, 16'h0000, 1'b0);
		send_pair(16'h8000, 16'h8000, 1'b1);
		settle();
	endtask

	task automatic test_zero_bin_size();
		write_bin_size({16'hA5A5, 16'h0000});
		send_pair(16'h7FFF, 16'h8001, 1'b0);
		send_pair(16'h0002, 16'h0000, 1'b1);
		settle();
	endtask

	task automatic test_bin_size_lowered();
		write_bin_size(32'd8);
		repeat (5) send_pair(rand_sample(), rand_sample(), 1'b0);
		settle();
		write_bin_size(32'd3);
		send_pair(rand_sample(), rand_sample(), 1'b0);
		settle();
	endtask

	task automatic test_max_bin_size();
		write_bin_size({16'h5A5A, 16'hFFFF});
		send_pair(16'h8000, 16'h0001, 1'b0);
		send_pair(16'h4000, 16'h0000, 1'b0);
		send_pair(16'h0000, 16'hC000, 1'b1);
		settle();
	endtask

	task automatic test_random_stream(input int n_items, input int send_pct, input int recv_pct);
		int                    sent;
		logic [PDATA_BITS-1:0] word;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		while (sent < n_items) begin
			settle();
			word = $urandom;
			word[SPB_BITS-1:0] = rand_bin_size();
			write_bin_size(word);
			for (int k = 0; k < BLOCK_ITEMS && sent < n_items; k++) begin
				send_pair(rand_sample(), rand_sample(), $urandom_range(24) == 0);
				sent++;
			end
		end
		settle();
	endtask

	always @(posedge clk)
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		column_t got;
		column_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {left_level, right_level, last_of_frame};
			if (pending_columns.size() == 0) begin
				if (errors < REPORT_LIMIT)
					$display("%0t: unexpected column: got L=%0d R=%0d last=%0b", $time,
						got.left_level, got.right_level, got.last_of_frame);
				errors++;
			end else begin
				want = pending_columns.pop_front();
				if (got !== want) begin
					if (errors < REPORT_LIMIT)
						$display("%0t: column mismatch: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
							$time, want.left_level, want.right_level, want.last_of_frame,
							got.left_level, got.right_level, got.last_of_frame);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		send_idle_pct = 35;
		recv_idle_pct = 54;
		test_reset_bin_size();
		test_level_extremes();
		test_frame_close();
		test_zero_bin_size();
		test_bin_size_lowered();
		test_max_bin_size();
		test_random_stream(280, 35, 54);
		test_random_stream(280, 54, 35);
		test_random_stream(280, 0, 0);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### files.f
rtl/swba_pkg.sv
rtl/swba_front.sv
rtl/swba_queue.sv
rtl/swba_div.sv
rtl/stereo_waveform_bin_averager_top.sv
rtl/swba_checker.sv
dv/tb.sv
